// ===== src/circular_orbit_phase_sincos_macros.svh =====
// Assertion macros shared by the orbit phase block.
`ifndef CIRCULAR_ORBIT_PHASE_SINCOS_MACROS_SVH
`define CIRCULAR_ORBIT_PHASE_SINCOS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cops_pkg.sv =====
package cops_pkg;

  localparam logic [1:0] REG_FIXED_BODY  = 2'd0;
  localparam logic [1:0] REG_TURN_RATE   = 2'd1;
  localparam logic [1:0] REG_RADIUS      = 2'd2;
  localparam logic [1:0] REG_START_PHASE = 2'd3;

  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  typedef struct packed {
    logic               done;
    logic signed [32:0] cos_v;
    logic signed [32:0] sin_v;
  } cordic_res_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MINC = 11'b000_0000_0010,
    S_MS1  = 11'b000_0000_0100,
    S_MS2  = 11'b000_0000_1000,
    S_CORD = 11'b000_0001_0000,
    S_MPX  = 11'b000_0010_0000,
    S_MPZ  = 11'b000_0100_0000,
    S_MVX  = 11'b000_1000_0000,
    S_MVZ  = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/cops_mul.sv =====
module cops_mul (
  input  logic                clk,
  input  logic                en,
  input  logic signed [35:0]  a,
  input  logic signed [33:0]  b,
  output logic signed [69:0]  p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ===== src/cops_cordic.sv =====
module cops_cordic #(
  parameter int STEPS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         phase,
  output cops_pkg::cordic_res_t res
);

  localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

  logic               busy;
  logic               done;
  logic [IW-1:0]      iter;
  logic [1:0]         quad;
  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [32:0] z;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] da;

  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign da = signed'({3'b000, cops_pkg::atan_turn(5'(iter))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        if (iter == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= cops_pkg::CORDIC_GAIN_Q30;
      y    <= '0;
      z    <= signed'({3'b000, phase[29:0]});
      quad <= phase[31:30];
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  always_comb begin
    res.done = done;
    case (quad)
      2'd0: begin
        res.cos_v = x;
        res.sin_v = y;
      end
      2'd1: begin
        res.cos_v = -y;
        res.sin_v = x;
      end
      2'd2: begin
        res.cos_v = -x;
        res.sin_v = -y;
      end
      default: begin
        res.cos_v = y;
        res.sin_v = -x;
      end
    endcase
  end

endmodule

// ===== src/circular_orbit_phase_sincos.sv =====
// Circular orbit step. Each item carries a time step; the block advances the
// phase by delta_time times turn_rate, runs an iterative CORDIC for cos and
// sin, and returns the new phase, position and velocity. A moving step runs
// one CORDIC micro-rotation per cycle and seven passes through the single
// shared multiplier, and the block takes no new step until its result is taken.
// A step of a fixed body, or one with a zero turn rate, repeats the last
// position and velocity.
// Configuration writes take effect at once and are meant for an idle block.
`include "circular_orbit_phase_sincos_macros.svh"

module circular_orbit_phase_sincos #(
  parameter int CORDIC_STEPS = 20,
  parameter int PHASE_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               step_valid,
  output logic               step_stall,
  input  logic [23:0]        delta_time,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               updated,
  output logic [31:0]        phase,
  output logic signed [24:0] pos_x,
  output logic signed [24:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_z
);

  localparam logic [31:0] PHASE_MASK = ~(32'hFFFF_FFFF >> PHASE_BITS);

  cops_pkg::state_t      state;
  cops_pkg::cordic_res_t cres;

  logic               is_fixed_body;
  logic [31:0]        turn_rate;
  logic [23:0]        orbit_radius;
  logic [23:0]        dt;
  logic [34:0]        spd;
  logic               mul_en;
  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [69:0] prod;
  logic               cordic_start;
  logic signed [33:0] cos_ext;
  logic signed [33:0] sin_ext;
  logic               idle_step;

  function automatic logic signed [24:0] pos_round(input logic signed [69:0] v);
    logic signed [69:0] r;
    r = (v + 70'sd536870912) >>> 30;
    if (r > 70'sd16777215) begin
      return 25'sh0FF_FFFF;
    end else if (r < -70'sd16777216) begin
      return 25'sh100_0000;
    end
    return r[24:0];
  endfunction

  function automatic logic signed [31:0] vel_round(input logic signed [69:0] v);
    logic signed [69:0] r;
    r = (v + 70'sd8388608) >>> 24;
    if (r > 70'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (r < -70'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return r[31:0];
  endfunction

  assign step_stall   = (state != cops_pkg::S_IDLE);
  assign result_valid = (state == cops_pkg::S_OUT);
  assign idle_step    = is_fixed_body || (turn_rate == 32'd0);
  assign cordic_start = (state == cops_pkg::S_MS2);
  assign cos_ext      = {cres.cos_v[32], cres.cos_v};
  assign sin_ext      = {cres.sin_v[32], cres.sin_v};

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      cops_pkg::S_MINC: begin
        mul_a = signed'({12'd0, dt});
        mul_b = signed'({2'b00, turn_rate});
      end
      cops_pkg::S_MS1: begin
        mul_a = signed'({12'd0, orbit_radius});
        mul_b = signed'({2'b00, turn_rate});
      end
      cops_pkg::S_MS2: begin
        mul_a = signed'({4'd0, prod[55:24]});
        mul_b = signed'({2'b00, cops_pkg::TWO_PI_Q29});
      end
      cops_pkg::S_MPX: begin
        mul_a = signed'({12'd0, orbit_radius});
        mul_b = cos_ext;
      end
      cops_pkg::S_MPZ: begin
        mul_a = signed'({12'd0, orbit_radius});
        mul_b = sin_ext;
      end
      cops_pkg::S_MVX: begin
        mul_a = signed'({1'b0, spd});
        mul_b = sin_ext >>> 6;
      end
      cops_pkg::S_MVZ: begin
        mul_a = signed'({1'b0, spd});
        mul_b = cos_ext >>> 6;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  cops_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  cops_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .phase (phase),
    .res   (cres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cops_pkg::S_IDLE;
      is_fixed_body <= 1'b0;
      turn_rate     <= '0;
      orbit_radius  <= '0;
      phase         <= '0;
      updated       <= 1'b0;
      pos_x         <= '0;
      pos_z         <= '0;
      vel_x         <= '0;
      vel_z         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          cops_pkg::REG_FIXED_BODY:  is_fixed_body <= cfg_data[0];
          cops_pkg::REG_TURN_RATE:   turn_rate     <= cfg_data;
          cops_pkg::REG_RADIUS:      orbit_radius  <= cfg_data[23:0];
          cops_pkg::REG_START_PHASE: phase         <= cfg_data & PHASE_MASK;
          default: ;
        endcase
      end
      case (state)
        cops_pkg::S_IDLE: begin
          if (step_valid) begin
            if (idle_step) begin
              updated <= 1'b0;
              state   <= cops_pkg::S_OUT;
            end else begin
              state <= cops_pkg::S_MINC;
            end
          end
        end
        cops_pkg::S_MINC: state <= cops_pkg::S_MS1;
        cops_pkg::S_MS1: begin
          phase <= (phase + prod[47:16]) & PHASE_MASK;
          state <= cops_pkg::S_MS2;
        end
        cops_pkg::S_MS2: state <= cops_pkg::S_CORD;
        cops_pkg::S_CORD: begin
          if (cres.done) begin
            spd   <= prod[63:29];
            state <= cops_pkg::S_MPX;
          end
        end
        cops_pkg::S_MPX: state <= cops_pkg::S_MPZ;
        cops_pkg::S_MPZ: begin
          pos_x <= pos_round(prod);
          state <= cops_pkg::S_MVX;
        end
        cops_pkg::S_MVX: begin
          pos_z <= pos_round(prod);
          state <= cops_pkg::S_MVZ;
        end
        cops_pkg::S_MVZ: begin
          vel_x <= vel_round(-prod);
          state <= cops_pkg::S_FIN;
        end
        cops_pkg::S_FIN: begin
          vel_z   <= vel_round(prod);
          updated <= 1'b1;
          state   <= cops_pkg::S_OUT;
        end
        cops_pkg::S_OUT: begin
          if (!result_stall) begin
            state <= cops_pkg::S_IDLE;
          end
        end
        default: state <= cops_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == cops_pkg::S_IDLE && step_valid) begin
      dt <= delta_time;
    end
  end

  `COPS_ASSERT_NOW(a_no_accept_while_result, result_valid, step_stall, "item accepted while result pending")
  `COPS_ASSERT_NOW(a_cordic_done_in_wait, cres.done, state == cops_pkg::S_CORD, "CORDIC finished outside its wait state")
  `COPS_ASSERT_NEXT(a_still_step_fast, step_valid && !step_stall && idle_step && !cfg_write, result_valid && !updated, "motionless step not answered at once")
  `COPS_ASSERT_NEXT(a_phase_held_idle, state == cops_pkg::S_IDLE && !cfg_write, $stable(phase), "phase moved while idle")

endmodule
